FILE: hw/rtl/pll_mnr_divider_search_defines.svh
// Assertion macros used by the PLL divider search RTL.
`ifndef PLL_MNR_DIVIDER_SEARCH_DEFINES_SVH
`define PLL_MNR_DIVIDER_SEARCH_DEFINES_SVH
`ifndef SYNTH
`define PMDS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pmds: assertion failed");
`define PMDS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   `PMDS_ASSERT(lbl, clk, rst, (ante) |-> (cons))
`else
`define PMDS_ASSERT(lbl, clk, rst, prop)
`define PMDS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/pmds_pkg.sv
// Types and constants of the PLL divider search.
package pmds_pkg;

   localparam int REF_W      = 16;
   localparam int M_W        = 8;
   localparam int N_W        = 6;
   localparam int R_W        = 3;
   localparam int RO_W       = 4;
   localparam int VCO_W      = 20;
   localparam int TGT_W      = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // N + 2 and M + 2 operands
   localparam int NP_W       = N_W + 1;
   localparam int MP_W       = M_W + 1;

   // Target shifted by the largest post-divider exponent (max_r + 1 = 8)
   localparam int VCO_SH_W   = TGT_W + 8;

   // Shared divider: dividend, divisor and step counter widths
   localparam int DIVD_W     = 35;
   localparam int DIVS_W     = 16;
   localparam int CNT_W      = 6;

   // Product register covers target * (N + 2) and ref * (M + 2)
   localparam int PROD_W     = TGT_W + NP_W;
   localparam int FOUT_W     = REF_W + MP_W;
   localparam int F_SHIFT    = DIVD_W - FOUT_W;

   localparam logic [CNT_W-1:0] Q_STEPS = CNT_W'(DIVD_W);
   localparam logic [CNT_W-1:0] F_STEPS = CNT_W'(FOUT_W);

   localparam logic [REF_W-1:0] RST_REF_KHZ = 16'd14318;
   localparam logic [M_W-1:0]   RST_MAX_M   = 8'd127;
   localparam logic [N_W-1:0]   RST_MAX_N   = 6'd31;
   localparam logic [R_W-1:0]   RST_MAX_R   = 3'd3;
   localparam logic [VCO_W-1:0] RST_MIN_VCO = 20'd180000;
   localparam logic [VCO_W-1:0] RST_MAX_VCO = 20'd360000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_KHZ = 3'd0,
      CSR_MAX_M   = 3'd1,
      CSR_MAX_N   = 3'd2,
      CSR_MAX_R   = 3'd3,
      CSR_MIN_VCO = 3'd4,
      CSR_MAX_VCO = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RSEL,
      ST_MUL_Q,
      ST_LOAD_Q,
      ST_DIV_Q,
      ST_MUL_F,
      ST_LOAD_F,
      ST_DIV_F,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [REF_W-1:0] ref_khz;
      logic [M_W-1:0]   max_m;
      logic [N_W-1:0]   max_n;
      logic [R_W-1:0]   max_r;
      logic [VCO_W-1:0] min_vco_khz;
      logic [VCO_W-1:0] max_vco_khz;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
      logic [CNT_W-1:0]  steps;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [M_W-1:0]   m_value;
      logic [N_W-1:0]   n_value;
      logic [RO_W-1:0]  r_value;
      logic [TGT_W-1:0] abs_error_khz;
      logic             found;
   } result_type;

endpackage

FILE: hw/rtl/pmds_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module pmds_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pmds_pkg::div_req_type div_req,
   output pmds_pkg::div_rsp_type div_rsp
);

   logic [pmds_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [pmds_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [pmds_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [pmds_pkg::DIVS_W-1:0] dsr_ff, dsr_in;
   logic [pmds_pkg::DIVS_W:0]   rem_sh;
   logic [pmds_pkg::DIVS_W:0]   rem_sub;
   logic                        ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[pmds_pkg::DIVD_W-1]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         cnt_in = div_req.steps;
         quo_in = div_req.dividend;
         rem_in = '0;
         dsr_in = div_req.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - pmds_pkg::CNT_W'(1);
         quo_in = {quo_ff[pmds_pkg::DIVD_W-2:0], ge};
         rem_in = ge ? rem_sub[pmds_pkg::DIVS_W-1:0] : rem_sh[pmds_pkg::DIVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy     = cnt_ff != '0;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: hw/rtl/pmds_search.sv
// Sequencer and datapath of the R selection and the search over N.
`include "pll_mnr_divider_search_defines.svh"

module pmds_search (
   input  logic                        clock,
   input  logic                        reset,
   input  pmds_pkg::cfg_type           cfg,
   input  logic                        start,
   input  logic [pmds_pkg::TGT_W-1:0]  target_khz,
   output logic                        idle,
   output logic                        res_valid,
   input  logic                        res_take,
   output pmds_pkg::result_type        res
);

   pmds_pkg::state_type state_ff, state_in;

   logic [pmds_pkg::TGT_W-1:0]  target_ff, target_in;
   logic [pmds_pkg::RO_W-1:0]   r_ff, r_in;
   logic [pmds_pkg::N_W-1:0]    n_ff, n_in;
   logic [pmds_pkg::M_W-1:0]    m_ff, m_in;
   logic [pmds_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [pmds_pkg::FOUT_W-1:0] fout_ff, fout_in;
   logic [pmds_pkg::TGT_W-1:0]  best_err_ff, best_err_in;
   logic [pmds_pkg::M_W-1:0]    best_m_ff, best_m_in;
   logic [pmds_pkg::N_W-1:0]    best_n_ff, best_n_in;
   logic                        hit_ff, hit_in;

   pmds_pkg::div_req_type div_req;
   pmds_pkg::div_rsp_type div_rsp;

   logic [pmds_pkg::VCO_SH_W-1:0] vco;
   logic                          r_fit;
   logic                          r_last;
   logic                          n_last;
   logic [pmds_pkg::NP_W-1:0]     n_plus2;
   logic [pmds_pkg::MP_W-1:0]     m_plus2;
   logic [pmds_pkg::PROD_W-1:0]   q_prod;
   logic [pmds_pkg::FOUT_W-1:0]   f_prod;
   logic [pmds_pkg::DIVD_W-1:0]   q_dividend;
   logic [pmds_pkg::DIVS_W-1:0]   f_divisor;
   logic [pmds_pkg::DIVD_W-1:0]   q_max;
   logic                          q_ok;
   logic [pmds_pkg::FOUT_W-1:0]   tgt_ext;
   logic [pmds_pkg::FOUT_W-1:0]   err;
   logic                          better;

   pmds_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      vco     = pmds_pkg::VCO_SH_W'(target_ff) << r_ff;
      r_fit   = (vco >= pmds_pkg::VCO_SH_W'(cfg.min_vco_khz)) &&
                (vco <  pmds_pkg::VCO_SH_W'(cfg.max_vco_khz));
      r_last  = r_ff[pmds_pkg::R_W-1:0] == cfg.max_r;
      n_last  = n_ff == cfg.max_n;
      n_plus2 = {1'b0, n_ff} + pmds_pkg::NP_W'(2);
      m_plus2 = {1'b0, m_ff} + pmds_pkg::MP_W'(2);
      q_prod  = target_ff * n_plus2;
      f_prod  = cfg.ref_khz * m_plus2;
      q_dividend = (pmds_pkg::DIVD_W'(prod_ff) << r_ff) +
                   pmds_pkg::DIVD_W'(cfg.ref_khz[pmds_pkg::REF_W-1:1]);
      f_divisor  = pmds_pkg::DIVS_W'(n_plus2) << r_ff;
      q_max   = pmds_pkg::DIVD_W'(cfg.max_m) + pmds_pkg::DIVD_W'(2);
      q_ok    = (div_rsp.quotient >= pmds_pkg::DIVD_W'(2)) && (div_rsp.quotient <= q_max);
      tgt_ext = pmds_pkg::FOUT_W'(target_ff);
      err     = (tgt_ext >= fout_ff) ? (tgt_ext - fout_ff) : (fout_ff - tgt_ext);
      better  = err < pmds_pkg::FOUT_W'(best_err_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pmds_pkg::ST_IDLE: begin
            if (start) state_in = pmds_pkg::ST_RSEL;
         end
         pmds_pkg::ST_RSEL: begin
            if (r_fit || r_last) begin
               state_in = (cfg.ref_khz == '0) ? pmds_pkg::ST_DONE : pmds_pkg::ST_MUL_Q;
            end
         end
         pmds_pkg::ST_MUL_Q:  state_in = pmds_pkg::ST_LOAD_Q;
         pmds_pkg::ST_LOAD_Q: state_in = pmds_pkg::ST_DIV_Q;
         pmds_pkg::ST_DIV_Q: begin
            if (!div_rsp.busy) begin
               if (q_ok)        state_in = pmds_pkg::ST_MUL_F;
               else if (n_last) state_in = pmds_pkg::ST_DONE;
               else             state_in = pmds_pkg::ST_MUL_Q;
            end
         end
         pmds_pkg::ST_MUL_F:  state_in = pmds_pkg::ST_LOAD_F;
         pmds_pkg::ST_LOAD_F: state_in = pmds_pkg::ST_DIV_F;
         pmds_pkg::ST_DIV_F: begin
            if (!div_rsp.busy) state_in = pmds_pkg::ST_CMP;
         end
         pmds_pkg::ST_CMP: begin
            state_in = n_last ? pmds_pkg::ST_DONE : pmds_pkg::ST_MUL_Q;
         end
         pmds_pkg::ST_DONE: begin
            if (res_take) state_in = pmds_pkg::ST_IDLE;
         end
         default: state_in = pmds_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      idle             = state_ff == pmds_pkg::ST_IDLE;
      res_valid        = state_ff == pmds_pkg::ST_DONE;
      div_req.start    = 1'b0;
      div_req.dividend = q_dividend;
      div_req.divisor  = cfg.ref_khz;
      div_req.steps    = pmds_pkg::Q_STEPS;
      case (state_ff)
         pmds_pkg::ST_LOAD_Q: begin
            div_req.start = 1'b1;
         end
         pmds_pkg::ST_LOAD_F: begin
            div_req.start    = 1'b1;
            div_req.dividend = {prod_ff[pmds_pkg::FOUT_W-1:0], pmds_pkg::F_SHIFT'(0)};
            div_req.divisor  = f_divisor;
            div_req.steps    = pmds_pkg::F_STEPS;
         end
         default: begin
         end
      endcase
      res.m_value       = best_m_ff;
      res.n_value       = best_n_ff;
      res.r_value       = r_ff;
      res.abs_error_khz = best_err_ff;
      res.found         = hit_ff;
   end

   // Datapath register updates
   always_comb begin
      target_in   = target_ff;
      r_in        = r_ff;
      n_in        = n_ff;
      m_in        = m_ff;
      prod_in     = prod_ff;
      fout_in     = fout_ff;
      best_err_in = best_err_ff;
      best_m_in   = best_m_ff;
      best_n_in   = best_n_ff;
      hit_in      = hit_ff;
      case (state_ff)
         pmds_pkg::ST_IDLE: begin
            if (start) begin
               target_in   = target_khz;
               r_in        = '0;
               n_in        = '0;
               best_err_in = target_khz;
               best_m_in   = '0;
               best_n_in   = '0;
               hit_in      = 1'b0;
            end
         end
         pmds_pkg::ST_RSEL: begin
            // Stepping past max_r leaves R at max_r + 1 when nothing fits.
            if (!r_fit) r_in = r_ff + pmds_pkg::RO_W'(1);
         end
         pmds_pkg::ST_MUL_Q: begin
            prod_in = q_prod;
         end
         pmds_pkg::ST_DIV_Q: begin
            if (!div_rsp.busy) begin
               if (q_ok)         m_in = div_rsp.quotient[pmds_pkg::M_W-1:0] - pmds_pkg::M_W'(2);
               else if (!n_last) n_in = n_ff + pmds_pkg::N_W'(1);
            end
         end
         pmds_pkg::ST_MUL_F: begin
            prod_in = pmds_pkg::PROD_W'(f_prod);
         end
         pmds_pkg::ST_DIV_F: begin
            if (!div_rsp.busy) fout_in = div_rsp.quotient[pmds_pkg::FOUT_W-1:0];
         end
         pmds_pkg::ST_CMP: begin
            if (better) begin
               best_err_in = err[pmds_pkg::TGT_W-1:0];
               best_m_in   = m_ff;
               best_n_in   = n_ff;
               hit_in      = 1'b1;
            end
            if (!n_last) n_in = n_ff + pmds_pkg::N_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      r_ff        <= r_in;
      n_ff        <= n_in;
      m_ff        <= m_in;
      prod_ff     <= prod_in;
      fout_ff     <= fout_in;
      best_err_ff <= best_err_in;
      best_m_ff   <= best_m_in;
      best_n_ff   <= best_n_in;
      hit_ff      <= hit_in;
   end

   // The divider is only restarted once the previous division has finished.
   `PMDS_ASSERT_IMPL(a_div_start_free, clock, reset, div_req.start, !div_rsp.busy)
   // The best error only ever shrinks from the target.
   `PMDS_ASSERT_IMPL(a_best_le_target, clock, reset, state_ff != pmds_pkg::ST_IDLE, best_err_ff <= target_ff)
   // Without a hit the chosen dividers stay at zero.
   `PMDS_ASSERT_IMPL(a_miss_zero, clock, reset, (state_ff != pmds_pkg::ST_IDLE) && !hit_ff, (best_m_ff == '0) && (best_n_ff == '0))
   // A hit always improves strictly on the target.
   `PMDS_ASSERT_IMPL(a_hit_below, clock, reset, (state_ff != pmds_pkg::ST_IDLE) && hit_ff, best_err_ff < target_ff)

endmodule

FILE: hw/rtl/pll_mnr_divider_search.sv
// Top level of the PLL divider search: settings registers, sequencer and result register.
// Per item, R is stepped up from 0 until the VCO fits or max_r is passed (1..max_r+1 trials);
// then each N from 0 to max_n is either rejected on its M or tried, and the result is registered.
// Each N uses one shared bit-serial divider (35 steps, then 25 more when the N is tried).
// A new item is taken once the previous result sits in the output register.
// Synchronous reset restores the default settings, empties the output and idles the sequencer.
module pll_mnr_divider_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pmds_pkg::TGT_W-1:0]          req_target_khz,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pmds_pkg::M_W-1:0]            rsp_m_value,
   output logic [pmds_pkg::N_W-1:0]            rsp_n_value,
   output logic [pmds_pkg::RO_W-1:0]           rsp_r_value,
   output logic [pmds_pkg::TGT_W-1:0]          rsp_abs_error_khz,
   output logic                                rsp_found,
   input  logic                                csr_write_en,
   input  logic [pmds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pmds_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Settings registers. Writes to indexes beyond the last register are
   // simply dropped.
   pmds_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            pmds_pkg::CSR_REF_KHZ: cfg_in.ref_khz     = csr_data[pmds_pkg::REF_W-1:0];
            pmds_pkg::CSR_MAX_M:   cfg_in.max_m       = csr_data[pmds_pkg::M_W-1:0];
            pmds_pkg::CSR_MAX_N:   cfg_in.max_n       = csr_data[pmds_pkg::N_W-1:0];
            pmds_pkg::CSR_MAX_R:   cfg_in.max_r       = csr_data[pmds_pkg::R_W-1:0];
            pmds_pkg::CSR_MIN_VCO: cfg_in.min_vco_khz = csr_data[pmds_pkg::VCO_W-1:0];
            pmds_pkg::CSR_MAX_VCO: cfg_in.max_vco_khz = csr_data[pmds_pkg::VCO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_khz     <= pmds_pkg::RST_REF_KHZ;
         cfg_ff.max_m       <= pmds_pkg::RST_MAX_M;
         cfg_ff.max_n       <= pmds_pkg::RST_MAX_N;
         cfg_ff.max_r       <= pmds_pkg::RST_MAX_R;
         cfg_ff.min_vco_khz <= pmds_pkg::RST_MIN_VCO;
         cfg_ff.max_vco_khz <= pmds_pkg::RST_MAX_VCO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The search engine only takes an item while it is idle; the item is
   // accepted on the same edge that loads it into the engine.
   logic                 srch_idle;
   logic                 srch_res_valid;
   logic                 srch_res_take;
   pmds_pkg::result_type srch_res;

   pmds_search u_search (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .start      (req_valid),
      .target_khz (req_target_khz),
      .idle       (srch_idle),
      .res_valid  (srch_res_valid),
      .res_take   (srch_res_take),
      .res        (srch_res)
   );

   assign req_stall = !srch_idle;

   // Output register. It parts the engine from the result channel, so the
   // engine can start on the next item while this result waits to be taken.
   logic                 rsp_valid_ff, rsp_valid_in;
   pmds_pkg::result_type rsp_ff, rsp_in;

   always_comb begin
      srch_res_take = srch_res_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_in        = rsp_ff;
      if (srch_res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = srch_res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_m_value       = rsp_ff.m_value;
   assign rsp_n_value       = rsp_ff.n_value;
   assign rsp_r_value       = rsp_ff.r_value;
   assign rsp_abs_error_khz = rsp_ff.abs_error_khz;
   assign rsp_found         = rsp_ff.found;

endmodule

FILE: sim/tb_pll_mnr_divider_search.sv
// Self-checking testbench for the PLL divider search: directed corners, random targets, stalls.
module tb_pll_mnr_divider_search;
   timeunit 1ns;
   timeprecision 1ps;

   // The two indexes above the last register, which the block must ignore.
   localparam logic [pmds_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = pmds_pkg::CSR_IDX_W'(6);
   localparam logic [pmds_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = pmds_pkg::CSR_IDX_W'(7);

   localparam int unsigned TARGET_MAX = 400000;
   localparam int unsigned VCO_MAX    = 1048575;
   localparam int unsigned WAIT_MAX   = 17;
   // Every item yields a result, so a short pause after the last result is enough
   // before the settings are touched again.
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 200;
   // Long hold-off of the result side; several items fit into it at small max_n.
   localparam int HOLD_CYCLES   = 4000;
   // The slowest item has max_n of 63 and tries every N; the hold-off and the
   // longest stalls come on top, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 60000;

   localparam logic [pmds_pkg::TGT_W-1:0] EDGE_TARGETS [13] = '{
      19'd0, 19'd1, 19'd400000, 19'd22500, 19'd22499, 19'd179999, 19'd180000,
      19'd359999, 19'd360000, 19'd262144, 19'd131071, 19'd100000, 19'd14318
   };

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   logic                            req_stall;
   logic [pmds_pkg::TGT_W-1:0]      req_target_khz = '0;
   logic                            rsp_valid;
   logic                            rsp_stall      = 1'b0;
   logic [pmds_pkg::M_W-1:0]        rsp_m_value;
   logic [pmds_pkg::N_W-1:0]        rsp_n_value;
   logic [pmds_pkg::RO_W-1:0]       rsp_r_value;
   logic [pmds_pkg::TGT_W-1:0]      rsp_abs_error_khz;
   logic                            rsp_found;
   logic                            csr_write_en   = 1'b0;
   logic [pmds_pkg::CSR_IDX_W-1:0]  csr_index      = '0;
   logic [pmds_pkg::CSR_DATA_W-1:0] csr_data       = '0;

   // The testbench's own copy of the settings registers, as they stand after reset.
   pmds_pkg::cfg_type settings = '{
      ref_khz:     pmds_pkg::RST_REF_KHZ,
      max_m:       pmds_pkg::RST_MAX_M,
      max_n:       pmds_pkg::RST_MAX_N,
      max_r:       pmds_pkg::RST_MAX_R,
      min_vco_khz: pmds_pkg::RST_MIN_VCO,
      max_vco_khz: pmds_pkg::RST_MAX_VCO
   };

   logic [pmds_pkg::TGT_W-1:0] pending_targets [$];
   pmds_pkg::result_type       predicted_dividers [$];

   int  items_queued   = 0;
   int  items_accepted = 0;
   int  results_seen   = 0;
   int  results_found  = 0;
   int  setting_writes = 0;
   int  input_stalled  = 0;
   int  mismatches     = 0;
   int  idle_cycles    = 0;

   // Handshake observations taken at the rising edge, used by the falling-edge drivers.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic rsp_seen  = 1'b0;

   // When set, both sides draw random waits; when clear, neither side idles at all.
   bit   idling = 1'b0;
   int   send_wait = 0;
   int   rsp_wait  = 0;
   int   hold_left = 0;
   int   hold_requests = 0;
   int   hold_served   = 0;

   pll_mnr_divider_search dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_target_khz    (req_target_khz),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_m_value       (rsp_m_value),
      .rsp_n_value       (rsp_n_value),
      .rsp_r_value       (rsp_r_value),
      .rsp_abs_error_khz (rsp_abs_error_khz),
      .rsp_found         (rsp_found),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   // Works out the divider settings the block should report for one target under the
   // current settings. The smallest post-divider exponent that puts the VCO inside the
   // window is taken, or one past max_r when none does; then every N is tried with a
   // rounded M, and the first pair with a strictly smaller error than the best so far
   // wins, starting from the target itself as the bound.
   function automatic pmds_pkg::result_type search_dividers(
      input logic [pmds_pkg::TGT_W-1:0] target
   );
      longint unsigned      tgt, ref_clk, vco, quot, mval, fout, err, best_err, nplus;
      int unsigned          shift, r, n;
      bit                   fitted;
      pmds_pkg::result_type res;
      tgt      = target;
      ref_clk  = settings.ref_khz;
      shift    = int'(settings.max_r) + 1;
      fitted   = 1'b0;
      best_err = tgt;
      res      = '0;
      for (r = 0; r <= settings.max_r; r++) begin
         vco = tgt << r;
         if (!fitted && vco >= settings.min_vco_khz && vco < settings.max_vco_khz) begin
            shift  = r;
            fitted = 1'b1;
         end
      end
      // A zero reference leaves nothing to divide by, so the search finds nothing.
      if (ref_clk != 0) begin
         for (n = 0; n <= settings.max_n; n++) begin
            nplus = n + 2;
            quot  = (((tgt * nplus) << shift) + (ref_clk >> 1)) / ref_clk;
            if (quot >= 2 && quot - 2 <= settings.max_m) begin
               mval = quot - 2;
               fout = (ref_clk * (mval + 2)) / (nplus << shift);
               err  = (tgt >= fout) ? tgt - fout : fout - tgt;
               if (err < best_err) begin
                  best_err      = err;
                  res.m_value   = pmds_pkg::M_W'(mval);
                  res.n_value   = pmds_pkg::N_W'(n);
                  res.found     = 1'b1;
               end
            end
         end
      end
      res.r_value       = pmds_pkg::RO_W'(shift);
      res.abs_error_khz = pmds_pkg::TGT_W'(best_err);
      return res;
   endfunction

   function automatic int draw_wait();
      return idling ? int'($urandom_range(0, WAIT_MAX)) : 0;
   endfunction

   // Most random targets are aimed at the range where some post-divider fits the
   // VCO window, so that the search actually finds pairs; the rest spread over the
   // whole field, with the extremes now and then.
   function automatic logic [pmds_pkg::TGT_W-1:0] pick_target();
      int unsigned lo, hi;
      lo = settings.min_vco_khz >> settings.max_r;
      hi = (settings.max_vco_khz > TARGET_MAX) ? TARGET_MAX : settings.max_vco_khz;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return pmds_pkg::TGT_W'(1);
               default: return pmds_pkg::TGT_W'(TARGET_MAX);
            endcase
         end
         1, 2, 3, 4, 5, 6: begin
            if (settings.max_vco_khz > settings.min_vco_khz && hi > lo)
               return pmds_pkg::TGT_W'($urandom_range(hi - 1, lo));
            return pmds_pkg::TGT_W'($urandom_range(TARGET_MAX, 0));
         end
         default: return pmds_pkg::TGT_W'($urandom_range(TARGET_MAX, 0));
      endcase
   endfunction

   // Fills the bits above a register's width with noise; the block must drop them.
   function automatic logic [pmds_pkg::CSR_DATA_W-1:0] with_junk(input int unsigned value,
                                                                 input int width);
      return pmds_pkg::CSR_DATA_W'(value) | (pmds_pkg::CSR_DATA_W'($urandom) << width);
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   task automatic write_setting(input logic [pmds_pkg::CSR_IDX_W-1:0] index,
                                input logic [pmds_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (index)
         pmds_pkg::CSR_REF_KHZ: settings.ref_khz     = value[pmds_pkg::REF_W-1:0];
         pmds_pkg::CSR_MAX_M:   settings.max_m       = value[pmds_pkg::M_W-1:0];
         pmds_pkg::CSR_MAX_N:   settings.max_n       = value[pmds_pkg::N_W-1:0];
         pmds_pkg::CSR_MAX_R:   settings.max_r       = value[pmds_pkg::R_W-1:0];
         pmds_pkg::CSR_MIN_VCO: settings.min_vco_khz = value[pmds_pkg::VCO_W-1:0];
         pmds_pkg::CSR_MAX_VCO: settings.max_vco_khz = value[pmds_pkg::VCO_W-1:0];
         default: ;
      endcase
      setting_writes++;
   endtask

   task automatic load_settings(input int unsigned ref_clk, input int unsigned m_limit,
                                input int unsigned n_limit, input int unsigned r_limit,
                                input int unsigned vco_lo, input int unsigned vco_hi);
      write_setting(pmds_pkg::CSR_REF_KHZ, with_junk(ref_clk, pmds_pkg::REF_W));
      write_setting(pmds_pkg::CSR_MAX_M, with_junk(m_limit, pmds_pkg::M_W));
      write_setting(pmds_pkg::CSR_MAX_N, with_junk(n_limit, pmds_pkg::N_W));
      write_setting(pmds_pkg::CSR_MAX_R, with_junk(r_limit, pmds_pkg::R_W));
      write_setting(pmds_pkg::CSR_MIN_VCO, pmds_pkg::CSR_DATA_W'(vco_lo));
      write_setting(pmds_pkg::CSR_MAX_VCO, pmds_pkg::CSR_DATA_W'(vco_hi));
   endtask

   task automatic offer(input logic [pmds_pkg::TGT_W-1:0] target);
      pending_targets.push_back(target);
      items_queued++;
   endtask

   // Waits until every queued item has gone in and every result has come back.
   task automatic settle();
      while (items_accepted != items_queued || predicted_dividers.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic offer_random(input int count);
      repeat (count) offer(pick_target());
      settle();
   endtask

   // Sender: after each accepted item it draws a gap, then presents the next target.
   // The payload is held while the block stalls.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else if (!req_valid || req_taken) begin
         if (req_taken)
            send_wait = draw_wait();
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (pending_targets.size() != 0) begin
            req_valid      <= 1'b1;
            req_target_khz <= pending_targets.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: each result is held back for a drawn number of cycles once it is seen,
   // and on request the whole side holds off for a long stretch so that the block
   // backs up into its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  = 0;
         hold_left = 0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (rsp_taken)
            rsp_wait = draw_wait();
         else if (rsp_seen && rsp_wait > 0)
            rsp_wait--;
         if (hold_left > 0)
            hold_left--;
         rsp_stall <= (hold_left > 0) || (rsp_wait > 0);
      end
   end

   // Monitor: results are checked against the oldest prediction before the item taken
   // at the same edge, if any, is predicted and queued.
   always @(posedge clock) begin
      pmds_pkg::result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         rsp_seen  <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         rsp_seen  <= rsp_valid;
         if (req_valid && req_stall)
            input_stalled++;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_found === 1'b1)
               results_found++;
            if (predicted_dividers.size() == 0) begin
               $error("result with nothing pending: m_value %0d, n_value %0d, r_value %0d",
                      rsp_m_value, rsp_n_value, rsp_r_value);
               mismatches++;
            end else begin
               want = predicted_dividers.pop_front();
               check_field("m_value", 32'(want.m_value), 32'(rsp_m_value));
               check_field("n_value", 32'(want.n_value), 32'(rsp_n_value));
               check_field("r_value", 32'(want.r_value), 32'(rsp_r_value));
               check_field("abs_error_khz", 32'(want.abs_error_khz), 32'(rsp_abs_error_khz));
               check_field("found", 32'(want.found), 32'(rsp_found));
            end
         end
         if (req_valid && !req_stall) begin
            predicted_dividers.push_back(search_dividers(req_target_khz));
            items_accepted++;
         end
      end
   end

   // Watchdog: counts cycles in which neither side moves an item and no register is
   // written; a hung block ends the run here.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Reset settings first: extremes of the target, and targets on
      // either side of VCO window edges at the smallest and the largest post-divider.
      idling = 1'b0;
      foreach (EDGE_TARGETS[i])
         offer(EDGE_TARGETS[i]);
      settle();

      // Writes to the two unused indexes must leave every setting as it was.
      write_setting(CSR_SPARE_LO, pmds_pkg::CSR_DATA_W'($urandom));
      write_setting(CSR_SPARE_HI, pmds_pkg::CSR_DATA_W'($urandom));
      offer(pmds_pkg::TGT_W'(100000));
      settle();

      // A zero reference clock: nothing can be found.
      write_setting(pmds_pkg::CSR_REF_KHZ, '0);
      offer(pmds_pkg::TGT_W'(50000));
      offer('0);
      settle();

      // An inverted VCO window, then an empty one: no post-divider fits.
      load_settings(pmds_pkg::RST_REF_KHZ, pmds_pkg::RST_MAX_M, pmds_pkg::RST_MAX_N,
                    pmds_pkg::RST_MAX_R, 300000, 200000);
      offer(pmds_pkg::TGT_W'(150000));
      settle();
      write_setting(pmds_pkg::CSR_MIN_VCO, pmds_pkg::CSR_DATA_W'(250000));
      write_setting(pmds_pkg::CSR_MAX_VCO, pmds_pkg::CSR_DATA_W'(250000));
      offer(pmds_pkg::TGT_W'(250000));
      settle();

      // Every limit at its top, then the reference and the M, N and R limits at their bottom.
      load_settings(65535, 255, 63, 7, 0, VCO_MAX);
      offer(pmds_pkg::TGT_W'(TARGET_MAX));
      offer(pmds_pkg::TGT_W'(1));
      settle();
      load_settings(1, 0, 0, 0, 0, VCO_MAX);
      offer('0);
      offer(pmds_pkg::TGT_W'(1));
      offer(pmds_pkg::TGT_W'(2));
      settle();

      // Random part, phase by phase under different settings.
      idling = 1'b1;
      load_settings(pmds_pkg::RST_REF_KHZ, pmds_pkg::RST_MAX_M, pmds_pkg::RST_MAX_N,
                    pmds_pkg::RST_MAX_R, pmds_pkg::RST_MIN_VCO, pmds_pkg::RST_MAX_VCO);
      offer_random(120);

      idling = 1'b0;
      load_settings(27000, 255, 15, 7, 100000, TARGET_MAX);
      offer_random(80);

      // Small max_n makes items quick, so the long hold-off fills the block and its
      // input stall shows up while the sender keeps offering.
      idling = 1'b1;
      load_settings(pmds_pkg::RST_REF_KHZ, pmds_pkg::RST_MAX_M, 3, pmds_pkg::RST_MAX_R,
                    pmds_pkg::RST_MIN_VCO, pmds_pkg::RST_MAX_VCO);
      hold_requests++;
      offer_random(60);

      load_settings(65535, 255, 63, 7, 0, VCO_MAX);
      offer_random(20);

      idling = 1'b0;
      load_settings(1, 0, 0, 0, 0, 0);
      offer_random(20);

      repeat (4) begin
         idling = 1'($urandom_range(0, 1));
         load_settings($urandom_range(65535, 1), $urandom_range(255, 0),
                       $urandom_range(15, 0), $urandom_range(7, 0),
                       $urandom_range(500000, 0), $urandom_range(VCO_MAX, 0));
         offer_random(45);
      end

      // Let any stray result show itself before the verdict.
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d items under %0d register writes; %0d results checked, %0d found.",
               items_accepted, setting_writes, results_seen, results_found);
      $display("The block held its input back for %0d cycles during the run.", input_stalled);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
